>>> rtl/core/eids_pkg.sv
`default_nettype none

package eids_pkg;

  // Table and history sizes
  localparam int SetEntries   = 8;
  localparam int HistoryDepth = 8;

  localparam int IdentW = 16;
  localparam int CmdW   = 8;
  localparam int CntW   = $clog2(SetEntries + 1);
  localparam int HistW  = $clog2(HistoryDepth + 1);

  // Event type codes
  localparam logic [CmdW-1:0] EvtAddId    = CmdW'(1);
  localparam logic [CmdW-1:0] EvtRemoveId = CmdW'(2);
  localparam logic [CmdW-1:0] EvtLogOnly  = CmdW'(3);

  typedef enum logic [2:0] {
    StAdded    = 3'd0,
    StPresent  = 3'd1,
    StRemoved  = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4,
    StLogged   = 3'd5,
    StIgnored  = 3'd6
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [IdentW-1:0] ident;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [3:0]        member_cnt;
    logic [3:0]        event_cnt;
    logic [IdentW-1:0] echo_data;
  } out_word_t;

  // Table update request and lookup response
  typedef struct packed {
    logic add;
    logic remove;
  } cam_req_t;

  typedef struct packed {
    logic hit;
    logic full;
  } cam_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/event_driven_id_set.sv
`default_nettype none

// Channel  Direction  Word                 Handshake
// in       input      in_word_i  (in_word_t)   in_valid_i  / in_stall_o
// out      output     out_word_o (out_word_t)  out_valid_o / out_stall_i
//
// A word accepted into the input register settles through the match/free-pick
// logic and loads the result register when the result slot frees, where its
// result is offered; one word per cycle while the output drains.
// Reset clears the valid bits, the active count and the history count; slot
// contents are left as they are. An output stall holds the result and backs
// up into in_stall_o once the input register is also occupied.
module event_driven_id_set (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire eids_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output eids_pkg::out_word_t      out_word_o
);

  logic                       in_valid_q;
  eids_pkg::in_word_t         in_word_q;
  logic                       out_valid_q;
  eids_pkg::out_word_t        out_word_q, out_word_d;
  logic                       advance, accept_in;
  eids_pkg::cam_req_t         cam_req;
  eids_pkg::cam_rsp_t         cam_rsp;
  logic [eids_pkg::CntW-1:0]  cnt_after;
  logic [eids_pkg::HistW-1:0] hist_q, hist_d;

  // Move the held word into the result register when the result slot frees
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;

  eids_cam u_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ident_i (in_word_q.ident),
    .req_i   (cam_req),
    .rsp_o   (cam_rsp),
    .cnt_o   (cnt_after)
  );

  // Decode the event; the table changes only when the word advances
  always_comb begin
    cam_req               = '0;
    out_word_d.status     = eids_pkg::StIgnored;
    out_word_d.echo_data  = '0;
    out_word_d.member_cnt = 4'(cnt_after);
    out_word_d.event_cnt  = 4'(hist_d);
    unique case (in_word_q.command)
      eids_pkg::EvtAddId: begin
        if (cam_rsp.hit) begin
          out_word_d.status = eids_pkg::StPresent;
        end else if (cam_rsp.full) begin
          out_word_d.status = eids_pkg::StFull;
        end else begin
          out_word_d.status = eids_pkg::StAdded;
          cam_req.add       = advance;
        end
      end
      eids_pkg::EvtRemoveId: begin
        if (cam_rsp.hit) begin
          out_word_d.status = eids_pkg::StRemoved;
          cam_req.remove    = advance;
        end else begin
          out_word_d.status = eids_pkg::StNotFound;
        end
      end
      eids_pkg::EvtLogOnly: begin
        out_word_d.status    = eids_pkg::StLogged;
        out_word_d.echo_data = in_word_q.ident;
      end
      default: begin
        out_word_d.status = eids_pkg::StIgnored;
      end
    endcase
  end

  // Bump history on every event, stop at the depth
  always_comb begin
    hist_d = hist_q;
    if (hist_q < eids_pkg::HistW'(eids_pkg::HistoryDepth)) begin
      hist_d = hist_q + eids_pkg::HistW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
    end else begin
      in_valid_q  <= accept_in || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
      if (advance) begin
        hist_q <= hist_d;
      end
    end
  end

  // Payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  // Table never adds and removes in the same cycle
  a_req_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cam_req.add && cam_req.remove))
    else $error("add and remove requested together");

  // A successful add leaves at least one active entry
  a_add_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_req.add |=> (out_word_o.member_cnt != 4'd0))
    else $error("active count zero after add");

  // History only moves with a result and never passes the depth
  a_hist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_q <= eids_pkg::HistW'(eids_pkg::HistoryDepth)) and
    (!advance |=> $stable(hist_q)))
    else $error("history count out of range or moved without a result");

  // A stalled output with a held word keeps the input stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while result register blocked");
`endif

endmodule

`default_nettype wire

>>> rtl/core/eids_cam.sv
`default_nettype none

module eids_cam (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [eids_pkg::IdentW-1:0] ident_i,
  input  wire eids_pkg::cam_req_t          req_i,
  output eids_pkg::cam_rsp_t               rsp_o,
  output logic [eids_pkg::CntW-1:0]        cnt_o
);

  logic [eids_pkg::IdentW-1:0]     slot_q [eids_pkg::SetEntries];
  logic [eids_pkg::SetEntries-1:0] valid_q, valid_d;
  logic [eids_pkg::SetEntries-1:0] hit_vec, free_vec, free_oh;
  logic [eids_pkg::CntW-1:0]       cnt_q, cnt_d;

  // Compare every valid slot in parallel
  always_comb begin
    for (int i = 0; i < eids_pkg::SetEntries; i++) begin
      hit_vec[i] = valid_q[i] && (slot_q[i] == ident_i);
    end
  end

  // Isolate the lowest free slot
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + eids_pkg::SetEntries'(1));

  assign rsp_o.hit  = |hit_vec;
  assign rsp_o.full = &valid_q;

  always_comb begin
    valid_d = valid_q;
    if (req_i.add) begin
      valid_d = valid_q | free_oh;
    end else if (req_i.remove) begin
      valid_d = valid_q & ~hit_vec;
    end
  end

  assign cnt_d = cnt_q + eids_pkg::CntW'(req_i.add) - eids_pkg::CntW'(req_i.remove);
  assign cnt_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Slot contents carry no reset; a slot is only read while valid
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < eids_pkg::SetEntries; i++) begin
      if (req_i.add && free_oh[i]) begin
        slot_q[i] <= ident_i;
      end
    end
  end

endmodule

`default_nettype wire
